// ===== hdl/passive_serial_fpga_configurator_macros.svh =====
// ---------------------------------------------------------------------------
// passive serial configurator assertion macros
// shared concurrent assertion forms, clocked on clk, off during rst
// ---------------------------------------------------------------------------
`ifndef PASSIVE_SERIAL_FPGA_CONFIGURATOR_MACROS_SVH
`define PASSIVE_SERIAL_FPGA_CONFIGURATOR_MACROS_SVH

// same-cycle implication
`define PSFC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psfc assertion failed");

// next-cycle implication
`define PSFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psfc assertion failed");

`endif

// ===== hdl/psfc_pkg.sv =====
// ---------------------------------------------------------------------------
// psfc_pkg
// types and codes shared by the passive serial configurator files
// ---------------------------------------------------------------------------
package psfc_pkg;

  localparam int CFG_W      = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [CFG_W-1:0] RESET_WAIT_DEFAULT = 16'd10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_WAIT = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_BYTE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RESET    = 3'd1,
    PH_WAITLOW  = 3'd2,
    PH_WAITSTAT = 3'd3,
    PH_SHIFT    = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OUT_PENDING = 2'd0,
    OUT_SUCCESS = 2'd1,
    OUT_FAILURE = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [1:0] action;
    logic       skip_request;
    logic       status_pin;
    logic       cfg_done_pin;
    logic [7:0] data_byte;
    logic       final_byte;
  } cmd_t;

  // what the sequencer leaves for the result stage on one transaction
  typedef struct packed {
    logic       pulses;       // byte shifted: eight pulse results
    logic [7:0] data_byte;
    logic       pre_ncfg;
    outcome_t   pre_outcome;
    logic       post_ncfg;
    phase_t     post_phase;
    outcome_t   post_outcome;
    logic       post_data;
  } run_t;

endpackage

// ===== hdl/psfc_ifs.sv =====
// ---------------------------------------------------------------------------
// psfc channel interfaces
// valid/ready channels for command items and result items
// ---------------------------------------------------------------------------
interface psfc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       skip_request;
  logic       status_pin;
  logic       cfg_done_pin;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, action, skip_request, status_pin, cfg_done_pin,
                  data_byte, final_byte, input ready);
  modport sink (input valid, action, skip_request, status_pin, cfg_done_pin,
                data_byte, final_byte, output ready);
endinterface

interface psfc_res_if;
  logic       valid;
  logic       ready;
  logic       ncfg_level;
  logic       clock_pulse;
  logic       data_bit;
  logic [2:0] phase;
  logic [1:0] outcome;
  logic       pins_released;
  logic       last_of_run;

  modport source (output valid, ncfg_level, clock_pulse, data_bit, phase, outcome,
                  pins_released, last_of_run, input ready);
  modport sink (input valid, ncfg_level, clock_pulse, data_bit, phase, outcome,
                pins_released, last_of_run, output ready);
endinterface

// ===== hdl/passive_serial_fpga_configurator.sv =====
// ---------------------------------------------------------------------------
// passive_serial_fpga_configurator
// passive serial configuration sequencer with one result stage
// ---------------------------------------------------------------------------
//
//  channel  | role   | per transaction
//  ---------+--------+----------------------------------------------------
//  cmd      | sink   | start, tick with pin samples, data byte, or no-op
//  res      | source | one status result, or eight DCLK pulse results
//  apb      | slave  | reset_wait_ticks at byte address 0
//
//  a command is decoded and the sequencer state updated in the cycle it is
//  accepted; its results sit in the result register from the next cycle on.
//  a shifted byte holds the result register for eight transactions, and
//  every other command holds it for one transaction.
//  cmd is ready while the result register is empty or its last result leaves.
//  synchronous reset: phase idle, nCONFIG released high, outcome pending.
//
module passive_serial_fpga_configurator #(
  parameter int WAIT_COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psfc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [psfc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [psfc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  psfc_cmd_if.sink                            cmd,
  psfc_res_if.source                          res
);
  import psfc_pkg::*;

  // config register
  logic [CFG_W-1:0] reset_wait_ticks;
  logic             cfg_write;
  reg_idx_t         reg_idx;

  // sequencer hookup
  cmd_t   cmd_item;
  run_t   run_next;
  phase_t seq_phase;
  logic   cmd_accept;

  // result stage
  logic       res_valid;
  logic [2:0] res_idx;
  run_t       run;
  logic       res_last;
  phase_t     res_phase;

  // apb: single register, no wait states
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_wait_ticks <= RESET_WAIT_DEFAULT;
    end else if (cfg_write && reg_idx == REG_RESET_WAIT) begin
      reset_wait_ticks <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_RESET_WAIT: prdata = APB_DATA_W'(reset_wait_ticks);
      default:        prdata = '0;
    endcase
  end

  // command side
  assign cmd_item.action        = cmd.action;
  assign cmd_item.skip_request  = cmd.skip_request;
  assign cmd_item.status_pin    = cmd.status_pin;
  assign cmd_item.cfg_done_pin  = cmd.cfg_done_pin;
  assign cmd_item.data_byte     = cmd.data_byte;
  assign cmd_item.final_byte    = cmd.final_byte;

  // take a new command once the pending run is on its way out
  assign cmd.ready  = !res_valid || (res.ready && res_last);
  assign cmd_accept = cmd.valid && cmd.ready;

  psfc_ctrl #(
    .WAIT_COUNT_BITS(WAIT_COUNT_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (cmd_accept),
    .cmd        (cmd_item),
    .reset_wait (reset_wait_ticks),
    .run        (run_next),
    .phase      (seq_phase)
  );

  // result register: one run, walked by res_idx for a shifted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_idx   <= '0;
    end else if (cmd_accept) begin
      res_valid <= 1'b1;
      res_idx   <= '0;
    end else if (res_valid && res.ready) begin
      if (res_last) begin
        res_valid <= 1'b0;
      end else begin
        res_idx <= res_idx + 3'd1;
      end
    end
  end

  // payload carries no reset
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      run <= run_next;
    end
  end

  // the eighth pulse carries the state after the byte, earlier ones the shift state
  assign res_last  = !run.pulses || (res_idx == 3'd7);
  assign res_phase = res_last ? run.post_phase : PH_SHIFT;

  assign res.valid         = res_valid;
  assign res.ncfg_level    = res_last ? run.post_ncfg : run.pre_ncfg;
  assign res.clock_pulse   = run.pulses;
  assign res.data_bit      = run.pulses ? run.data_byte[res_idx] : run.post_data;
  assign res.phase         = res_phase;
  assign res.outcome       = res_last ? run.post_outcome : run.pre_outcome;
  assign res.pins_released = (res_phase == PH_IDLE) || (res_phase == PH_DONE);
  assign res.last_of_run   = res_last;

  // checks
  `include "passive_serial_fpga_configurator_macros.svh"

  `PSFC_ASSERT_SAME(a_no_accept_mid_run, clk, rst, res_valid && !res_last, !cmd_accept)
  `PSFC_ASSERT_SAME(a_mid_pulse_shifting, clk, rst, res_valid && !res_last, res_phase == PH_SHIFT && run.pulses)
  `PSFC_ASSERT_NEXT(a_byte_gives_pulse, clk, rst, cmd_accept && cmd.action == ACT_BYTE && seq_phase == PH_SHIFT, res_valid && run.pulses && res_idx == 3'd0)
  `PSFC_ASSERT_NEXT(a_stall_holds_index, clk, rst, res_valid && !res.ready && !cmd_accept, $stable(res_idx) && res_valid)

endmodule

// ===== hdl/psfc_ctrl.sv =====
// ---------------------------------------------------------------------------
// psfc_ctrl
// configuration sequencer state, advanced once per accepted command
// ---------------------------------------------------------------------------
module psfc_ctrl #(
  parameter int WAIT_COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  psfc_pkg::cmd_t              cmd,
  input  logic [psfc_pkg::CFG_W-1:0]  reset_wait,
  output psfc_pkg::run_t              run,
  output psfc_pkg::phase_t            phase
);
  import psfc_pkg::*;

  logic [WAIT_COUNT_BITS-1:0] wait_counter, wait_counter_next, wait_load, wait_dec;
  logic     any_byte_sent, any_byte_sent_next;
  logic     ncfg, ncfg_next;
  logic     data_level, data_level_next;
  outcome_t outcome, outcome_next;
  phase_t   phase_next;
  logic     pulses;

  assign wait_load = WAIT_COUNT_BITS'(reset_wait);
  assign wait_dec  = (wait_counter != '0) ? wait_counter - WAIT_COUNT_BITS'(1)
                                          : wait_counter;

  always_comb begin
    phase_next         = phase;
    wait_counter_next  = wait_counter;
    any_byte_sent_next = any_byte_sent;
    ncfg_next          = ncfg;
    data_level_next    = data_level;
    outcome_next       = outcome;
    pulses             = 1'b0;
    case (cmd.action)
      ACT_START: begin
        any_byte_sent_next = 1'b0;
        if (cmd.skip_request) begin
          outcome_next = OUT_SUCCESS;
          phase_next   = PH_DONE;
          ncfg_next    = 1'b1;
        end else begin
          outcome_next      = OUT_PENDING;
          ncfg_next         = 1'b0;
          wait_counter_next = wait_load;
          phase_next        = (wait_load == '0) ? PH_WAITLOW : PH_RESET;
        end
      end
      ACT_TICK: begin
        case (phase)
          PH_RESET: begin
            wait_counter_next = wait_dec;
            if (wait_dec == '0) phase_next = PH_WAITLOW;
          end
          PH_WAITLOW: begin
            if (!cmd.status_pin || !cmd.cfg_done_pin) begin
              ncfg_next  = 1'b1;
              phase_next = PH_WAITSTAT;
            end
          end
          PH_WAITSTAT: begin
            if (cmd.status_pin) phase_next = PH_SHIFT;
          end
          PH_SHIFT: begin
            if (cmd.cfg_done_pin && any_byte_sent) begin
              outcome_next = OUT_SUCCESS;
              phase_next   = PH_DONE;
              ncfg_next    = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ACT_BYTE: begin
        if (phase == PH_SHIFT) begin
          pulses             = 1'b1;
          data_level_next    = cmd.data_byte[7];
          any_byte_sent_next = 1'b1;
          if (cmd.cfg_done_pin) begin
            outcome_next = OUT_SUCCESS;
            phase_next   = PH_DONE;
            ncfg_next    = 1'b1;
          end else if (cmd.final_byte) begin
            outcome_next = OUT_FAILURE;
            phase_next   = PH_DONE;
            ncfg_next    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    run.pulses       = pulses;
    run.data_byte    = cmd.data_byte;
    run.pre_ncfg     = ncfg;
    run.pre_outcome  = outcome;
    run.post_ncfg    = ncfg_next;
    run.post_phase   = phase_next;
    run.post_outcome = outcome_next;
    run.post_data    = data_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_counter  <= '0;
      any_byte_sent <= 1'b0;
      ncfg          <= 1'b1;
      data_level    <= 1'b0;
      outcome       <= OUT_PENDING;
    end else if (accept) begin
      phase         <= phase_next;
      wait_counter  <= wait_counter_next;
      any_byte_sent <= any_byte_sent_next;
      ncfg          <= ncfg_next;
      data_level    <= data_level_next;
      outcome       <= outcome_next;
    end
  end

endmodule
